/* hw/rtl/assert_macros.svh */
// Assertion macros shared by the face normal RTL.
// Needs clk_i and rst_ni in the scope that uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// same-cycle implication
`define ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

/* hw/rtl/tfn_pkg.sv */
// Shared constants and types for the triangle face normal pipeline.
// No dependencies.
package tfn_pkg;
  localparam int unsigned COORD_BITS_DEF  = 24;
  localparam int unsigned NORMAL_BITS_DEF = 16;
  localparam int unsigned MAG_BITS        = 31;
  localparam int unsigned SUM_BITS        = 64;
  localparam int unsigned ROOT_STEPS      = 32;
  localparam int unsigned ROOT_BITS       = 32;

  typedef struct packed {
    logic [2:0]                neg;
    logic                      degen;
    logic [2:0][MAG_BITS-1:0]  mag;
  } norm_t;
endpackage

/* hw/rtl/triangle_face_normal.sv */
// Triangle face normal: top level, stall control and port assembly.
// Depends on tfn_pkg, tfn_front, tfn_sqrt, tfn_div and assert_macros.svh.
//
// Input channel tri_*: one request carries three vertices a, b, c, signed,
// COORD_BITS wide. Output channel nrm_*: the unit normal of (b-a) x (c-a),
// signed with NORMAL_BITS-1 fraction bits, and degenerate_o when the cross
// product is zero (normal then reads zero).
// Results reach nrm_valid_o through the front end, the 32-stage square root and
// the one-bit-per-stage divider. Throughput: one request per cycle while the
// receiver does not stall the output.
// The whole pipeline advances as one: it moves whenever the output register
// is empty or taken. When the receiver holds nrm_ready_i low with a result
// waiting, every stage holds and tri_ready_o drops; nothing is lost.
// Reset clears all valid bits; the datapath registers need no reset.
`include "assert_macros.svh"
module triangle_face_normal #(
  parameter int unsigned COORD_BITS  = tfn_pkg::COORD_BITS_DEF,
  parameter int unsigned NORMAL_BITS = tfn_pkg::NORMAL_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          tri_valid_i,
  output logic                          tri_ready_o,
  input  logic signed [COORD_BITS-1:0]  vertex_a_x_i,
  input  logic signed [COORD_BITS-1:0]  vertex_a_y_i,
  input  logic signed [COORD_BITS-1:0]  vertex_a_z_i,
  input  logic signed [COORD_BITS-1:0]  vertex_b_x_i,
  input  logic signed [COORD_BITS-1:0]  vertex_b_y_i,
  input  logic signed [COORD_BITS-1:0]  vertex_b_z_i,
  input  logic signed [COORD_BITS-1:0]  vertex_c_x_i,
  input  logic signed [COORD_BITS-1:0]  vertex_c_y_i,
  input  logic signed [COORD_BITS-1:0]  vertex_c_z_i,
  output logic                          nrm_valid_o,
  input  logic                          nrm_ready_i,
  output logic signed [NORMAL_BITS-1:0] normal_x_o,
  output logic signed [NORMAL_BITS-1:0] normal_y_o,
  output logic signed [NORMAL_BITS-1:0] normal_z_o,
  output logic                          degenerate_o
);
  logic                          en;
  logic [8:0][COORD_BITS-1:0]    coord;
  logic                          f_valid;
  tfn_pkg::norm_t                f_data;
  logic                          s_valid;
  tfn_pkg::norm_t                s_data;
  logic [tfn_pkg::ROOT_BITS-1:0] s_len;
  logic [2:0][NORMAL_BITS-1:0]   normal;

  assign en          = !nrm_valid_o || nrm_ready_i;
  assign tri_ready_o = en;
  assign coord = {vertex_c_z_i, vertex_c_y_i, vertex_c_x_i,
                  vertex_b_z_i, vertex_b_y_i, vertex_b_x_i,
                  vertex_a_z_i, vertex_a_y_i, vertex_a_x_i};

  tfn_front #(.CB(COORD_BITS)) u_front (
    .clk_i, .rst_ni, .en_i(en), .valid_i(tri_valid_i), .coord_i(coord),
    .valid_o(f_valid), .data_o(f_data)
  );

  tfn_sqrt u_sqrt (
    .clk_i, .rst_ni, .en_i(en), .valid_i(f_valid), .data_i(f_data),
    .valid_o(s_valid), .data_o(s_data), .len_o(s_len)
  );

  tfn_div #(.NB(NORMAL_BITS)) u_div (
    .clk_i, .rst_ni, .en_i(en), .valid_i(s_valid), .data_i(s_data),
    .len_i(s_len), .valid_o(nrm_valid_o), .normal_o(normal),
    .degen_o(degenerate_o)
  );

  assign normal_x_o = normal[0];
  assign normal_y_o = normal[1];
  assign normal_z_o = normal[2];

  `ASSERT_NOW(a_degen_zero, nrm_valid_o && degenerate_o,
    normal_x_o == '0 && normal_y_o == '0 && normal_z_o == '0)
  `ASSERT_NOW(a_nondegen_nonzero, nrm_valid_o && !degenerate_o,
    normal_x_o != '0 || normal_y_o != '0 || normal_z_o != '0)
  `ASSERT_NOW(a_single_unit_axis, nrm_valid_o && !degenerate_o,
    !(normal_x_o == {1'b1, {(NORMAL_BITS-1){1'b0}}} &&
      normal_y_o == {1'b1, {(NORMAL_BITS-1){1'b0}}}))
endmodule

/* hw/rtl/tfn_front.sv */
// Edges, cross product and normalization to 31-bit magnitudes (5 stages).
// Depends on tfn_pkg.
module tfn_front #(
  parameter int unsigned CB = tfn_pkg::COORD_BITS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  logic                       valid_i,
  input  logic [8:0][CB-1:0]         coord_i,
  output logic                       valid_o,
  output tfn_pkg::norm_t             data_o
);
  localparam int unsigned EW = CB + 1;
  localparam int unsigned PW = 2 * EW;
  localparam int unsigned CW = PW + 1;
  localparam int unsigned MW = 2 * CB + 2;
  localparam int unsigned LW = $clog2(MW + 1);
  localparam int unsigned SW = MW + tfn_pkg::MAG_BITS;

  logic [4:0] v_q;

  logic signed [EW-1:0] u_q [3];
  logic signed [EW-1:0] w_q [3];
  logic signed [PW-1:0] p_q [6];
  logic [MW-1:0]        m3_q [3];
  logic [2:0]           n3_q;
  logic [MW-1:0]        m4_q [3];
  logic [2:0]           n4_q;
  logic [LW-1:0]        l4_q;
  tfn_pkg::norm_t       data_q;

  logic signed [CW-1:0] c_d [3];
  logic [MW-1:0]        mag_d [3];
  logic [MW-1:0]        or_d;
  logic [LW-1:0]        l_d;
  tfn_pkg::norm_t       data_d;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      c_d[i] = '0;
    end
    c_d[0] = CW'(p_q[0]) - CW'(p_q[1]);
    c_d[1] = CW'(p_q[2]) - CW'(p_q[3]);
    c_d[2] = CW'(p_q[4]) - CW'(p_q[5]);
    for (int i = 0; i < 3; i++) begin
      mag_d[i] = c_d[i][CW-1] ? MW'(-c_d[i]) : MW'(c_d[i]);
    end
  end

  always_comb begin
    or_d = m3_q[0] | m3_q[1] | m3_q[2];
    l_d  = '0;
    for (int i = 0; i < MW; i++) begin
      if (or_d[i]) begin
        l_d = LW'(i + 1);
      end
    end
  end

  always_comb begin
    logic [SW-1:0] sh;
    data_d.neg   = n4_q;
    data_d.degen = (l4_q == '0);
    for (int i = 0; i < 3; i++) begin
      sh = {m4_q[i], tfn_pkg::MAG_BITS'(0)} >> l4_q;
      data_d.mag[i] = sh[tfn_pkg::MAG_BITS-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[3:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        u_q[i] <= EW'($signed(coord_i[3+i])) - EW'($signed(coord_i[i]));
        w_q[i] <= EW'($signed(coord_i[6+i])) - EW'($signed(coord_i[i]));
      end
      p_q[0] <= u_q[1] * w_q[2];
      p_q[1] <= u_q[2] * w_q[1];
      p_q[2] <= u_q[2] * w_q[0];
      p_q[3] <= u_q[0] * w_q[2];
      p_q[4] <= u_q[0] * w_q[1];
      p_q[5] <= u_q[1] * w_q[0];
      for (int i = 0; i < 3; i++) begin
        m3_q[i] <= mag_d[i];
        n3_q[i] <= c_d[i][CW-1];
      end
      m4_q   <= m3_q;
      n4_q   <= n3_q;
      l4_q   <= l_d;
      data_q <= data_d;
    end
  end

  assign valid_o = v_q[4];
  assign data_o  = data_q;
endmodule

/* hw/rtl/tfn_sqrt.sv */
// Sum of squares and bit-per-stage integer square root (34 stages).
// Depends on tfn_pkg.
module tfn_sqrt (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             en_i,
  input  logic                             valid_i,
  input  tfn_pkg::norm_t                   data_i,
  output logic                             valid_o,
  output tfn_pkg::norm_t                   data_o,
  output logic [tfn_pkg::ROOT_BITS-1:0]    len_o
);
  localparam int unsigned NS = tfn_pkg::ROOT_STEPS + 2;
  localparam int unsigned XW = tfn_pkg::SUM_BITS;
  localparam int unsigned QW = 2 * tfn_pkg::MAG_BITS;

  logic [NS-1:0]   v_q;
  tfn_pkg::norm_t  c_q [NS];
  logic [QW-1:0]   sq_q [3];
  logic [XW-1:0]   x_q [1:NS-1];
  logic [XW-1:0]   r_q [1:NS-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[NS-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      c_q[0] <= data_i;
      for (int i = 0; i < 3; i++) begin
        sq_q[i] <= QW'(data_i.mag[i]) * QW'(data_i.mag[i]);
      end
      c_q[1] <= c_q[0];
      x_q[1] <= XW'(sq_q[0]) + XW'(sq_q[1]) + XW'(sq_q[2]);
      r_q[1] <= '0;
    end
  end

  for (genvar k = 0; k < tfn_pkg::ROOT_STEPS; k++) begin : g_root
    logic [XW-1:0] bit_w;
    logic [XW-1:0] trial;
    logic [XW-1:0] x_d;
    logic [XW-1:0] r_d;
    always_comb begin
      bit_w = XW'(1) << (62 - 2 * k);
      trial = r_q[k+1] + bit_w;
      if (x_q[k+1] >= trial) begin
        x_d = x_q[k+1] - trial;
        r_d = (r_q[k+1] >> 1) + bit_w;
      end else begin
        x_d = x_q[k+1];
        r_d = r_q[k+1] >> 1;
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        x_q[k+2] <= x_d;
        r_q[k+2] <= r_d;
        c_q[k+2] <= c_q[k+1];
      end
    end
  end

  assign valid_o = v_q[NS-1];
  assign data_o  = c_q[NS-1];
  assign len_o   = r_q[NS-1][tfn_pkg::ROOT_BITS-1:0];
endmodule

/* hw/rtl/tfn_div.sv */
// Rounded division of each magnitude by the length, one quotient bit per
// stage, then sign and saturation into the output register. Depends on tfn_pkg.
module tfn_div #(
  parameter int unsigned NB = tfn_pkg::NORMAL_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             en_i,
  input  logic                             valid_i,
  input  tfn_pkg::norm_t                   data_i,
  input  logic [tfn_pkg::ROOT_BITS-1:0]    len_i,
  output logic                             valid_o,
  output logic [2:0][NB-1:0]               normal_o,
  output logic                             degen_o
);
  localparam int unsigned F  = NB - 1;
  localparam int unsigned RW = tfn_pkg::ROOT_BITS + F;
  localparam int unsigned LB = tfn_pkg::ROOT_BITS;

  logic [NB+1:0]    v_q;
  logic [RW-1:0]    rem_q [NB+1][3];
  logic [NB-1:0]    quo_q [NB+1][3];
  logic [LB-1:0]    len_q [NB+1];
  logic [3:0]       flg_q [NB+1];
  logic [2:0][NB-1:0] out_q;
  logic             deg_q;
  logic [2:0][NB-1:0] out_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[NB:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        rem_q[0][i] <= (RW'(data_i.mag[i]) << F) + RW'(len_i >> 1);
        quo_q[0][i] <= '0;
      end
      len_q[0] <= len_i;
      flg_q[0] <= {data_i.degen, data_i.neg};
    end
  end

  for (genvar j = 0; j < NB; j++) begin : g_step
    logic [RW-1:0] dsh;
    logic [RW-1:0] rem_d [3];
    logic [NB-1:0] quo_d [3];
    always_comb begin
      dsh = RW'(len_q[j]) << (F - j);
      for (int i = 0; i < 3; i++) begin
        rem_d[i] = rem_q[j][i];
        quo_d[i] = quo_q[j][i];
        if (rem_q[j][i] >= dsh) begin
          rem_d[i] = rem_q[j][i] - dsh;
          quo_d[i][F-j] = 1'b1;
        end
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[j+1] <= rem_d;
        quo_q[j+1] <= quo_d;
        len_q[j+1] <= len_q[j];
        flg_q[j+1] <= flg_q[j];
      end
    end
  end

  always_comb begin
    logic [NB-1:0] q;
    logic [NB-1:0] one;
    one = NB'(1) << F;
    for (int i = 0; i < 3; i++) begin
      q = quo_q[NB][i];
      if (flg_q[NB][3]) begin
        out_d[i] = '0;
      end else if (flg_q[NB][i]) begin
        out_d[i] = (q > one) ? -one : -q;
      end else begin
        out_d[i] = (q > one - NB'(1)) ? one - NB'(1) : q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      out_q <= out_d;
      deg_q <= flg_q[NB][3];
    end
  end

  assign valid_o  = v_q[NB+1];
  assign normal_o = out_q;
  assign degen_o  = deg_q;
endmodule
